>>> design/ple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  // item_value, position, padded to whole bytes
  localparam int IN_TDATA_W  = ((VALUE_W + POS_W + 7) / 8) * 8;
  // read_data, element_count, front_data, back_data, padded to whole bytes
  localparam int OUT_FIELDS_W = 3 * VALUE_W + COUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [VALUE_W-1:0] READ_MISS_VALUE = {1'b1, {(VALUE_W - 1){1'b0}}};

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_INSERT     = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_POP_FRONT  = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_READ       = 3'd6
  } op_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_INS    = 7'b0000010,
    S_INS_WR = 7'b0000100,
    S_DEL    = 7'b0001000,
    S_DEL_WR = 7'b0010000,
    S_RD     = 7'b0100000,
    S_FETCH  = 7'b1000000
  } state_t;

endpackage

>>> design/positional_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed 32-bit values with push, pop, insert,
// remove and read by position, one result word per input word.
// ----------------------------------------------------------------------------
// Path from the accept edge: pop back and failed ops other than read go straight
//   to S_FETCH; read passes S_RD first, push back writes in S_INS; insert, push
//   front, remove and pop front first move each entry with a read and a write state.
// Throughput: one word in flight; the next word is accepted at the edge where
//   out_tvalid rises, and a result still held on the output stalls fetch.
// Reset: synchronous active-low rst_n empties the list and clears control.
module positional_list_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [31:0] item_value, [35:32] position, [39:36] zero
  input  logic [ple_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [2:0] func
  input  logic [ple_pkg::FUNC_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] read_data, [36:32] element_count, [68:37] front_data,
  // [100:69] back_data, [103:101] zero
  output logic [ple_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [0] ok
  output logic                                out_tuser
);

  localparam int ADDR_W  = ple_pkg::ADDR_W;
  localparam int CNT_W   = ple_pkg::CNT_W;
  localparam int VALUE_W = ple_pkg::VALUE_W;

  ple_pkg::state_t state_r, state_nxt;
  ple_pkg::op_t    op_r, op_nxt, op_in;

  logic [VALUE_W-1:0] val_r;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic [ADDR_W-1:0]  at_r, at_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               ok_r, ok_nxt;
  logic [VALUE_W-1:0] rd_val_r, rd_val_nxt;

  logic [VALUE_W-1:0] store_r [ple_pkg::CAPACITY];
  logic [VALUE_W-1:0] rd_a_r, rd_b_r;
  logic               we;
  logic [ADDR_W-1:0]  waddr, ra, rb;
  logic [VALUE_W-1:0] wdata;

  logic                             out_valid_r;
  logic [ple_pkg::OUT_TDATA_W-1:0]  out_tdata_r;
  logic                             out_ok_r;

  logic               in_fire;
  logic [ADDR_W-1:0]  in_pos;
  logic               full, empty, pos_lt;
  logic [CNT_W-1:0]   idx_inc_c;
  logic [VALUE_W-1:0] front_v, back_v;

  assign op_in     = ple_pkg::op_t'(in_tuser);
  assign in_pos    = ADDR_W'(in_tdata[VALUE_W +: ple_pkg::POS_W]);
  assign in_tready = (state_r == ple_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign full      = (cnt_r == CNT_W'(ple_pkg::CAPACITY));
  assign empty     = (cnt_r == '0);
  assign pos_lt    = (CNT_W'(in_pos) < cnt_r);
  assign idx_inc_c = CNT_W'(idx_r) + 1'b1;

  // sequencer: each memory move takes a read state and a write state, shared address/compare path
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    idx_nxt    = idx_r;
    at_nxt     = at_r;
    cnt_nxt    = cnt_r;
    ok_nxt     = ok_r;
    rd_val_nxt = rd_val_r;
    we         = 1'b0;
    waddr      = idx_r;
    wdata      = rd_a_r;
    ra         = idx_r;
    rb         = ADDR_W'(cnt_r - 1'b1);
    case (state_r)
      ple_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = op_in;
          ok_nxt     = 1'b0;
          rd_val_nxt = '0;
          state_nxt  = ple_pkg::S_FETCH;
          case (op_in)
            ple_pkg::OP_PUSH_BACK: begin
              if (!full) begin
                ok_nxt    = 1'b1;
                idx_nxt   = ADDR_W'(cnt_r);
                at_nxt    = ADDR_W'(cnt_r);
                state_nxt = ple_pkg::S_INS;
              end
            end
            ple_pkg::OP_PUSH_FRONT: begin
              if (!full) begin
                ok_nxt    = 1'b1;
                idx_nxt   = ADDR_W'(cnt_r);
                at_nxt    = '0;
                state_nxt = ple_pkg::S_INS;
              end
            end
            ple_pkg::OP_INSERT: begin
              if (!full && pos_lt) begin
                ok_nxt    = 1'b1;
                idx_nxt   = ADDR_W'(cnt_r);
                at_nxt    = in_pos;
                state_nxt = ple_pkg::S_INS;
              end
            end
            ple_pkg::OP_POP_BACK: begin
              if (!empty) begin
                ok_nxt  = 1'b1;
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            ple_pkg::OP_POP_FRONT: begin
              if (!empty) begin
                ok_nxt    = 1'b1;
                idx_nxt   = '0;
                state_nxt = ple_pkg::S_DEL;
              end
            end
            ple_pkg::OP_REMOVE: begin
              if (pos_lt) begin
                ok_nxt    = 1'b1;
                idx_nxt   = in_pos;
                state_nxt = ple_pkg::S_DEL;
              end
            end
            ple_pkg::OP_READ: begin
              ok_nxt    = pos_lt;
              ra        = in_pos;
              state_nxt = ple_pkg::S_RD;
            end
            default: begin
              state_nxt = ple_pkg::S_FETCH;
            end
          endcase
        end
      end
      ple_pkg::S_INS: begin
        if (idx_r == at_r) begin
          we        = 1'b1;
          waddr     = at_r;
          wdata     = val_r;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ple_pkg::S_FETCH;
        end else begin
          ra        = idx_r - 1'b1;
          state_nxt = ple_pkg::S_INS_WR;
        end
      end
      ple_pkg::S_INS_WR: begin
        // move entry idx-1 up into idx
        we        = 1'b1;
        idx_nxt   = idx_r - 1'b1;
        state_nxt = ple_pkg::S_INS;
      end
      ple_pkg::S_DEL: begin
        if (idx_inc_c >= cnt_r) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = ple_pkg::S_FETCH;
        end else begin
          ra        = idx_r + 1'b1;
          state_nxt = ple_pkg::S_DEL_WR;
        end
      end
      ple_pkg::S_DEL_WR: begin
        // move entry idx+1 down into idx
        we        = 1'b1;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ple_pkg::S_DEL;
      end
      ple_pkg::S_RD: begin
        // word read at the accept edge lands now
        rd_val_nxt = ok_r ? rd_a_r : ple_pkg::READ_MISS_VALUE;
        state_nxt  = ple_pkg::S_FETCH;
      end
      ple_pkg::S_FETCH: begin
        // front and back fetched here, reissued while the output is held
        ra = '0;
        if (!out_valid_r || out_tready) begin
          state_nxt = ple_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ple_pkg::S_IDLE;
      end
    endcase
  end

  // list memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      store_r[waddr] <= wdata;
    end
    rd_a_r <= store_r[ra];
    rd_b_r <= store_r[rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ple_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    idx_r    <= idx_nxt;
    at_r     <= at_nxt;
    ok_r     <= ok_nxt;
    rd_val_r <= rd_val_nxt;
    if (in_fire) begin
      val_r <= in_tdata[VALUE_W-1:0];
    end
  end

  // result register: loaded once front/back data has arrived
  logic out_take;
  assign out_take = (state_r == ple_pkg::S_FETCH) && (!out_valid_r || out_tready);

  // the fetch cycle issues front/back reads; results are captured in the following cycle
  logic fin_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r <= 1'b0;
    end else begin
      fin_r <= out_take;
    end
  end

  assign front_v = empty ? '0 : rd_a_r;
  assign back_v  = empty ? '0 : rd_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_r) begin
      out_ok_r    <= ok_r;
      out_tdata_r <= {{(ple_pkg::OUT_TDATA_W - ple_pkg::OUT_FIELDS_W){1'b0}},
                      back_v, front_v, ple_pkg::COUNT_W'(cnt_r), rd_val_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_ok_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(ple_pkg::CAPACITY))
    else $error("element count above capacity");

  a_ins_above_gap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ple_pkg::S_INS_WR |-> idx_r > at_r)
    else $error("insert shift went below the gap");

  a_del_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ple_pkg::S_DEL_WR |-> idx_inc_c < cnt_r)
    else $error("remove shift read past the last element");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != $past(cnt_r) |->
      (cnt_r == $past(cnt_r) + 1'b1 || cnt_r + 1'b1 == $past(cnt_r)))
    else $error("element count moved by more than one");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> state_r == ple_pkg::S_IDLE && !$past(in_fire))
    else $error("result captured while another word was in flight");

endmodule

>>> bench/ple_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_list_checker
// Watches both stream channels of the positional list engine. Keeps its own
// copy of the list, works out the result word of every accepted input word,
// and compares each accepted result word field by field against the oldest
// one waiting.
// ----------------------------------------------------------------------------
module ple_list_checker
  import ple_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [FUNC_W-1:0]      in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tuser,
  output int                     mismatches,
  output int                     pending,
  output int                     occupancy,
  output int                     results_checked,
  output int                     results_ok,
  output int                     full_rejects,
  output int                     empty_rejects
);

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] read_data;
    logic [COUNT_W-1:0] element_count;
    logic [VALUE_W-1:0] front_data;
    logic [VALUE_W-1:0] back_data;
  } list_result_t;

  logic [VALUE_W-1:0] cells [CAPACITY];
  int                 fill;
  list_result_t       expected_q [$];

  initial begin
    mismatches      = 0;
    pending         = 0;
    occupancy       = 0;
    results_checked = 0;
    results_ok      = 0;
    full_rejects    = 0;
    empty_rejects   = 0;
    fill            = 0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // applies one operation to the shadow list and returns its result word
  function automatic list_result_t apply_op(input logic [FUNC_W-1:0] func,
                                            input logic [VALUE_W-1:0] value,
                                            input logic [POS_W-1:0] pos);
    list_result_t r;
    int           i;
    r = '0;
    case (func)
      OP_PUSH_BACK: begin
        if (fill < CAPACITY) begin
          cells[fill] = value;
          fill++;
          r.ok = 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (fill < CAPACITY) begin
          for (i = fill; i > 0; i--) cells[i] = cells[i-1];
          cells[0] = value;
          fill++;
          r.ok = 1'b1;
        end
      end
      OP_INSERT: begin
        if (fill < CAPACITY && int'(pos) < fill) begin
          for (i = fill; i > int'(pos); i--) cells[i] = cells[i-1];
          cells[pos] = value;
          fill++;
          r.ok = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (fill > 0) begin
          fill--;
          r.ok = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (fill > 0) begin
          for (i = 0; i + 1 < fill; i++) cells[i] = cells[i+1];
          fill--;
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (int'(pos) < fill) begin
          for (i = int'(pos); i + 1 < fill; i++) cells[i] = cells[i+1];
          fill--;
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (int'(pos) < fill) begin
          r.read_data = cells[pos];
          r.ok        = 1'b1;
        end else begin
          r.read_data = READ_MISS_VALUE;
        end
      end
      default: ;
    endcase
    r.element_count = fill[COUNT_W-1:0];
    r.front_data    = (fill > 0) ? cells[0] : '0;
    r.back_data     = (fill > 0) ? cells[fill-1] : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    logic [FUNC_W-1:0] func;
    int fill_before;
    if (!rst_n) begin
      fill = 0;
      expected_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        func        = in_tuser;
        fill_before = fill;
        want = apply_op(func, in_tdata[VALUE_W-1:0], in_tdata[VALUE_W +: POS_W]);
        if (!want.ok) begin
          if (fill_before == CAPACITY &&
              (func == OP_PUSH_BACK || func == OP_PUSH_FRONT || func == OP_INSERT))
            full_rejects++;
          if (fill_before == 0 && (func == OP_POP_BACK || func == OP_POP_FRONT ||
                                   func == OP_REMOVE || func == OP_READ))
            empty_rejects++;
        end
        expected_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.ok            = out_tuser;
        got.read_data     = out_tdata[31:0];
        got.element_count = out_tdata[36:32];
        got.front_data    = out_tdata[68:37];
        got.back_data     = out_tdata[100:69];
        if (expected_q.size() == 0) begin
          report("unexpected result word", got.read_data, '0);
        end else begin
          want = expected_q.pop_front();
          results_checked++;
          if (got.ok) results_ok++;
          if (got.ok !== want.ok) report("ok", 32'(got.ok), 32'(want.ok));
          if (got.read_data !== want.read_data)
            report("read_data", got.read_data, want.read_data);
          if (got.element_count !== want.element_count)
            report("element_count", 32'(got.element_count), 32'(want.element_count));
          if (got.front_data !== want.front_data)
            report("front_data", got.front_data, want.front_data);
          if (got.back_data !== want.back_data)
            report("back_data", got.back_data, want.back_data);
        end
      end
    end
    pending   <= expected_q.size();
    occupancy <= fill;
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the positional list engine: a directed run over empty, single
// element and invalid position cases, then random grow, shrink and mixed
// phases with random gaps on the input side and random stalls on the output.
// ----------------------------------------------------------------------------
module tb;
  import ple_pkg::*;

  localparam int                RANDOM_WORDS = 1500;
  localparam int                CYCLE_LIMIT  = 1000000;
  localparam int                DRAIN_CYCLES = 2 * CAPACITY + 10;
  localparam logic [FUNC_W-1:0] OP_UNUSED    = 3'd7;

  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED  = 2;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [FUNC_W-1:0]      in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  int mismatches, pending, occupancy;
  int results_checked, results_ok, full_rejects, empty_rejects;

  int   cycle_count = 0;
  int   words_sent  = 0;
  int   ready_hold  = 0;
  int   ready_roll;
  logic no_stall    = 1'b0;

  always #5 clk = ~clk;

  positional_list_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  ple_list_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .mismatches      (mismatches),
    .pending         (pending),
    .occupancy       (occupancy),
    .results_checked (results_checked),
    .results_ok      (results_ok),
    .full_rejects    (full_rejects),
    .empty_rejects   (empty_rejects)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side back-pressure: mostly short stalls, now and then a long one
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (no_stall) begin
      out_tready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 55) begin
        out_tready <= 1'b1;
        ready_hold <= $urandom_range(0, 6);
      end else if (ready_roll < 93) begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(10, 40);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_stall || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2:       return 32'h7fff_ffff;
      3:       return READ_MISS_VALUE;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value,
                           input logic [POS_W-1:0] pos);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {{(IN_TDATA_W - VALUE_W - POS_W){1'b0}}, pos, value};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input int mode);
    int                r;
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  pos;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW: begin
        if (r < 35)      func = OP_PUSH_BACK;
        else if (r < 55) func = OP_PUSH_FRONT;
        else if (r < 80) func = OP_INSERT;
        else if (r < 88) func = OP_READ;
        else             func = FUNC_W'($urandom_range(0, 7));
      end
      MODE_SHRINK: begin
        if (r < 30)      func = OP_POP_BACK;
        else if (r < 50) func = OP_POP_FRONT;
        else if (r < 75) func = OP_REMOVE;
        else if (r < 88) func = OP_READ;
        else             func = FUNC_W'($urandom_range(0, 7));
      end
      default: func = FUNC_W'($urandom_range(0, 7));
    endcase
    // mostly aim at a live index, sometimes anywhere
    if ($urandom_range(0, 99) < 80 && occupancy > 0)
      pos = POS_W'($urandom_range(0, occupancy - 1));
    else
      pos = POS_W'($urandom_range(0, 15));
    send_word(func, pick_value(), pos);
  endtask

  initial begin
    int mode;
    int phase_left;
    int n;
    mode       = MODE_GROW;
    phase_left = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, single element lists, edge values and bad indexes
    send_word(OP_READ,       '0,           4'd0);
    send_word(OP_POP_BACK,   '0,           4'd0);
    send_word(OP_POP_FRONT,  '0,           4'd0);
    send_word(OP_REMOVE,     '0,           4'd0);
    send_word(OP_INSERT,     32'h1234_5678, 4'd0);
    send_word(OP_PUSH_BACK,  32'h7fff_ffff, 4'd15);
    send_word(OP_POP_BACK,   '0,           4'd0);
    send_word(OP_PUSH_FRONT, READ_MISS_VALUE, 4'd0);
    send_word(OP_POP_FRONT,  '0,           4'd0);
    send_word(OP_PUSH_BACK,  32'd1,        4'd0);
    send_word(OP_INSERT,     32'h0bad_0bad, 4'd1);
    send_word(OP_INSERT,     '1,           4'd0);
    send_word(OP_PUSH_FRONT, 32'h5a5a_5a5a, 4'd0);
    send_word(OP_INSERT,     32'ha5a5_a5a5, 4'd2);
    send_word(OP_READ,       '0,           4'd0);
    send_word(OP_READ,       '0,           4'd3);
    send_word(OP_READ,       '0,           4'd4);
    send_word(OP_READ,       '1,           4'd15);
    send_word(OP_REMOVE,     '0,           4'd1);
    send_word(OP_REMOVE,     '0,           4'd9);
    send_word(OP_UNUSED,     '1,           4'd15);
    send_word(OP_POP_FRONT,  '0,           4'd0);
    send_word(OP_POP_BACK,   '0,           4'd0);
    send_word(OP_READ,       '0,           4'd0);

    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (phase_left == 0) begin
        mode       = $urandom_range(MODE_GROW, MODE_MIXED);
        phase_left = $urandom_range(30, 60);
        no_stall  <= ($urandom_range(0, 3) == 0);
      end
      send_random(mode);
      phase_left--;
    end
    in_tvalid <= 1'b0;
    no_stall  <= 1'b0;

    // let the last accepted word show up in the outstanding count
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d list operations, checked %0d results, %0d of them succeeded",
             words_sent, results_checked, results_ok);
    $display("full list refusals: %0d, empty list refusals: %0d, mismatches: %0d",
             full_rejects, empty_rejects, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
